>>> sv/kdlp_pkg.sv
// ----------------------------------------------------------------------------
// kdlp_pkg
// shared types and constants of the key debounce / long press block
// ----------------------------------------------------------------------------
package kdlp_pkg;

    localparam int NUM_KEYS    = 3;
    localparam int KIDX_W      = 2;
    localparam int FILT_W      = 8;
    localparam int HOLD_W      = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [HOLD_W-1:0] HOLD_MAX = {HOLD_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_TIME   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_TIME     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESSED_LEVEL = 2'd2;

    localparam logic [FILT_W-1:0] FILTER_TIME_RST = 8'd20;
    localparam logic [HOLD_W-1:0] LONG_TIME_RST   = 16'd1000;

    typedef enum logic [1:0] {
        EV_DOWN = 2'd0,
        EV_UP   = 2'd1,
        EV_LONG = 2'd2
    } ev_kind_t;

    // events of one tick, one slot per key
    typedef struct packed {
        logic     [NUM_KEYS-1:0] mask;
        ev_kind_t [NUM_KEYS-1:0] kind;
    } tick_ev_t;

endpackage

>>> sv/kdlp_front.sv
// ----------------------------------------------------------------------------
// kdlp_front
// config registers, per-key debounce state and event classification
// ----------------------------------------------------------------------------
module kdlp_front import kdlp_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [NUM_KEYS-1:0]   s_key_levels,
    input  logic                  q_full,
    output logic                  q_push,
    output tick_ev_t              q_wdata
);

    logic [FILT_W-1:0] filter_time_reg;
    logic [HOLD_W-1:0] long_time_reg;
    logic              pressed_level_reg;

    logic [FILT_W-1:0] filt_reg  [NUM_KEYS];
    logic [FILT_W-1:0] filt_next [NUM_KEYS];
    logic [HOLD_W-1:0] hold_reg  [NUM_KEYS];
    logic [HOLD_W-1:0] hold_next [NUM_KEYS];
    logic [NUM_KEYS-1:0] stable_reg;
    logic [NUM_KEYS-1:0] stable_next;
    tick_ev_t          ev;
    logic              accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign q_push  = accept && (|ev.mask);
    assign q_wdata = ev;

    always_comb begin
        ev          = '0;
        stable_next = stable_reg;
        for (int i = 0; i < NUM_KEYS; i++) begin
            filt_next[i] = filt_reg[i];
            hold_next[i] = hold_reg[i];
            ev.kind[i]   = EV_DOWN;
            if (s_key_levels[i] == pressed_level_reg) begin
                if (filt_reg[i] < filter_time_reg) begin
                    filt_next[i] = filt_reg[i] + 1'b1;
                end else if (!stable_reg[i]) begin
                    stable_next[i] = 1'b1;
                    ev.mask[i]     = 1'b1;
                    ev.kind[i]     = EV_DOWN;
                end else if (hold_reg[i] != HOLD_MAX) begin
                    hold_next[i] = hold_reg[i] + 1'b1;
                    if (hold_reg[i] == long_time_reg) begin
                        ev.mask[i] = 1'b1;
                        ev.kind[i] = EV_LONG;
                    end
                end
            end else begin
                if (filt_reg[i] != '0) begin
                    filt_next[i] = filt_reg[i] - 1'b1;
                end else begin
                    if (stable_reg[i]) begin
                        stable_next[i] = 1'b0;
                        ev.mask[i]     = 1'b1;
                        ev.kind[i]     = EV_UP;
                    end
                    hold_next[i] = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_time_reg   <= FILTER_TIME_RST;
            long_time_reg     <= LONG_TIME_RST;
            pressed_level_reg <= 1'b0;
            stable_reg        <= '0;
            for (int i = 0; i < NUM_KEYS; i++) begin
                filt_reg[i] <= '0;
                hold_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_FILTER_TIME:   filter_time_reg   <= cfg_wdata[FILT_W-1:0];
                    CFG_LONG_TIME:     long_time_reg     <= cfg_wdata[HOLD_W-1:0];
                    CFG_PRESSED_LEVEL: pressed_level_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end
            if (accept) begin
                stable_reg <= stable_next;
                for (int i = 0; i < NUM_KEYS; i++) begin
                    filt_reg[i] <= filt_next[i];
                    hold_reg[i] <= hold_next[i];
                end
            end
        end
    end

endmodule

>>> sv/kdlp_queue.sv
// ----------------------------------------------------------------------------
// kdlp_queue
// short fifo of per-tick event sets between front and back
// ----------------------------------------------------------------------------
module kdlp_queue import kdlp_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  tick_ev_t wdata,
    output logic     full,
    input  logic     pop,
    output logic     not_empty,
    output tick_ev_t rdata
);

    tick_ev_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wptr_reg;
    logic [QPTR_W-1:0]   rptr_reg;
    logic [QCNT_W-1:0]   cnt_reg;
    logic [QCNT_W-1:0]   cnt_next;

    assign full      = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign rdata     = mem_reg[rptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wptr_reg <= (wptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= (rptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
        end
    end

endmodule

>>> sv/kdlp_back.sv
// ----------------------------------------------------------------------------
// kdlp_back
// serializes the events of one tick in key order into the output register
// ----------------------------------------------------------------------------
module kdlp_back import kdlp_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_not_empty,
    input  tick_ev_t          q_rdata,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [KIDX_W-1:0] m_key_index,
    output logic [1:0]        m_event_kind,
    output logic              m_last
);

    logic [NUM_KEYS-1:0] done_reg;
    logic [NUM_KEYS-1:0] done_next;
    logic [NUM_KEYS-1:0] pending;
    logic [NUM_KEYS-1:0] low_bit;
    logic [KIDX_W-1:0]   sel;
    logic                is_last;
    logic                load;

    logic                m_valid_reg;
    logic [KIDX_W-1:0]   m_key_index_reg;
    ev_kind_t            m_event_kind_reg;
    logic                m_last_reg;

    assign pending = q_rdata.mask & ~done_reg;
    assign low_bit = pending & (~pending + 1'b1);
    assign is_last = ((pending & ~low_bit) == '0);
    assign load    = q_not_empty && (!m_valid_reg || m_ready);
    assign q_pop   = load && is_last;

    always_comb begin
        sel = '0;
        for (int i = 0; i < NUM_KEYS; i++) begin
            if (low_bit[i]) begin
                sel = KIDX_W'(i);
            end
        end
    end

    always_comb begin
        done_next = done_reg;
        if (load) begin
            done_next = is_last ? '0 : (done_reg | low_bit);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            done_reg    <= '0;
        end else begin
            done_reg <= done_next;
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_key_index_reg  <= sel;
            m_event_kind_reg <= q_rdata.kind[sel];
            m_last_reg       <= is_last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_key_index  = m_key_index_reg;
    assign m_event_kind = m_event_kind_reg;
    assign m_last       = m_last_reg;

endmodule

>>> sv/key_debounce_long_press.sv
// ----------------------------------------------------------------------------
// key_debounce_long_press
// integrating key debounce with down, up and long-press events
// ----------------------------------------------------------------------------
// One scan tick is taken whenever the two-entry event queue has room, so ticks
// may arrive back to back. The front updates every key's filter, pressed flag
// and hold count in the cycle a tick is taken and queues the tick's events; a
// tick with no event is consumed without any output. The back sends one event
// per cycle from its output register while m_ready is high, lowest key first,
// with m_last on the final event of a tick, so the output port sets the
// sustained rate of one event per cycle. s_ready is already high when reset ends.
module key_debounce_long_press import kdlp_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [NUM_KEYS-1:0]   s_key_levels,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [KIDX_W-1:0]     m_key_index,
    output logic [1:0]            m_event_kind,
    output logic                  m_last
);

    logic     q_full;
    logic     q_push;
    logic     q_pop;
    logic     q_not_empty;
    tick_ev_t q_wdata;
    tick_ev_t q_rdata;

    kdlp_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_key_levels (s_key_levels),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_wdata      (q_wdata)
    );

    kdlp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .wdata     (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .rdata     (q_rdata)
    );

    kdlp_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_not_empty  (q_not_empty),
        .q_rdata      (q_rdata),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_key_index  (m_key_index),
        .m_event_kind (m_event_kind),
        .m_last       (m_last)
    );

endmodule

>>> sv/kdlp_checker.sv
// ----------------------------------------------------------------------------
// kdlp_checker
// port-level checks of the key debounce block, bound to the top level
// ----------------------------------------------------------------------------
module kdlp_checker import kdlp_pkg::*; (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input logic [KIDX_W-1:0] m_key_index,
    input logic [1:0]        m_event_kind,
    input logic              m_last
);

    // a stalled transaction holds its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_key_index)
            && $stable(m_event_kind) && $stable(m_last))
        else $error("output changed while stalled");

    // events of one tick follow without a gap, in rising key order
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid
            && (m_key_index > $past(m_key_index)))
        else $error("events of a tick out of order or split");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_key_index < KIDX_W'(NUM_KEYS))
            && (m_event_kind != 2'd3))
        else $error("bad key index or event kind");

    // a non-final event can never belong to the last key
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> m_key_index != KIDX_W'(NUM_KEYS - 1))
        else $error("last key event not marked last");

    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind key_debounce_long_press kdlp_checker u_kdlp_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_key_index  (m_key_index),
    .m_event_kind (m_event_kind),
    .m_last       (m_last)
);

>>> verif/tb_key_debounce_long_press.sv
// ----------------------------------------------------------------------------
// tb_key_debounce_long_press
// self-checking bench for the key debounce / long press block
// ----------------------------------------------------------------------------
// Scan ticks go in on the s_ channel and key events come out on the m_
// channel. A scoreboard class carries its own copy of each key's filter count,
// pressed flag and hold count, so every accepted tick yields its list of down,
// up and long events. Each event that comes out is checked against the oldest
// one still pending. The run has these parts:
// - short directed sequences: zero filter time, a filter time lowered below a
//   running count, and both pressed levels
// - a 20-tick filter on all keys with an early long event
// - rounds of random key activity under several register settings, all but the
//   last with random gaps on the sender and random stalls on the receiver
// ----------------------------------------------------------------------------
module tb_key_debounce_long_press;
    timeunit 1ns;
    timeprecision 1ps;
    import kdlp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE_CYCLES = 4;
    localparam int NUM_ROUNDS   = 8;
    localparam int ROUND_TICKS  = 50;
    localparam int MAX_REPORTS  = 20;

    typedef struct packed {
        logic [KIDX_W-1:0] key;
        ev_kind_t          kind;
        logic              last;
    } key_event_t;

    class kdlp_scoreboard;
        logic [FILT_W-1:0] filter_time;
        logic [HOLD_W-1:0] long_time;
        logic              pressed_level;
        logic [FILT_W-1:0] filt_cnt [NUM_KEYS];
        logic              held     [NUM_KEYS];
        logic [HOLD_W-1:0] hold_cnt [NUM_KEYS];
        key_event_t        pending [$];
        int errors;
        int n_ticks;
        int n_events;

        function new();
            filter_time   = FILTER_TIME_RST;
            long_time     = LONG_TIME_RST;
            pressed_level = 1'b0;
            for (int k = 0; k < NUM_KEYS; k++) begin
                filt_cnt[k] = '0;
                held[k]     = 1'b0;
                hold_cnt[k] = '0;
            end
            errors   = 0;
            n_ticks  = 0;
            n_events = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_FILTER_TIME:   filter_time   = data[FILT_W-1:0];
                CFG_LONG_TIME:     long_time     = data[HOLD_W-1:0];
                CFG_PRESSED_LEVEL: pressed_level = data[0];
                default: ;
            endcase
        endfunction

        // one accepted tick: update every key and queue its events in key order
        function void note_tick(logic [NUM_KEYS-1:0] levels);
            key_event_t evs [NUM_KEYS];
            int n;
            n = 0;
            n_ticks++;
            for (int k = 0; k < NUM_KEYS; k++) begin
                if (levels[k] == pressed_level) begin
                    if (filt_cnt[k] < filter_time) begin
                        filt_cnt[k]++;
                    end else if (!held[k]) begin
                        held[k] = 1'b1;
                        evs[n]  = '{KIDX_W'(k), EV_DOWN, 1'b0};
                        n++;
                    end else if (hold_cnt[k] != HOLD_MAX) begin
                        // long fires on the old value, counter stops at max
                        if (hold_cnt[k] == long_time) begin
                            evs[n] = '{KIDX_W'(k), EV_LONG, 1'b0};
                            n++;
                        end
                        hold_cnt[k]++;
                    end
                end else begin
                    if (filt_cnt[k] != '0) begin
                        filt_cnt[k]--;
                    end else begin
                        if (held[k]) begin
                            held[k] = 1'b0;
                            evs[n]  = '{KIDX_W'(k), EV_UP, 1'b0};
                            n++;
                        end
                        hold_cnt[k] = '0;
                    end
                end
            end
            for (int i = 0; i < n; i++) begin
                evs[i].last = (i == n - 1);
                pending.push_back(evs[i]);
            end
        endfunction

        function void check_event(logic [KIDX_W-1:0] key, logic [1:0] kind, logic last);
            key_event_t want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected event: expected none, got key %0d kind %0d last %0d",
                             $time, key, kind, last);
                return;
            end
            want = pending.pop_front();
            n_events++;
            if (key !== want.key || kind !== want.kind || last !== want.last) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: mismatch: expected key %0d kind %0d last %0d, got %0d %0d %0d",
                             $time, want.key, want.kind, want.last, key, kind, last);
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic [NUM_KEYS-1:0]   s_key_levels;
    logic                  m_valid;
    logic                  m_ready;
    logic [KIDX_W-1:0]     m_key_index;
    logic [1:0]            m_event_kind;
    logic                  m_last;

    kdlp_scoreboard sb;
    int  cycle_count = 0;
    int  n_settings  = 0;
    int  gap_pct     = 0;
    bit  idling_on   = 1'b1;

    // random key activity: each key follows a target level with runs of random length
    logic [NUM_KEYS-1:0] target;
    int                  run_left [NUM_KEYS];

    key_debounce_long_press dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_key_levels (s_key_levels),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_key_index  (m_key_index),
        .m_event_kind (m_event_kind),
        .m_last       (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d events still pending",
                     cycle_count, sb.pending.size());
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_event(m_key_index, m_event_kind, m_last);
    end

    // receiver: runs in stretches, each with its own stall rate
    initial begin
        int stall_left;
        int stretch_left;
        int stall_pct;
        stall_left   = 0;
        stretch_left = 0;
        stall_pct    = 0;
        m_ready <= 1'b0;
        forever begin
            @(negedge aclk);
            if (stretch_left == 0) begin
                stretch_left = 50;
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 20;
                    default: stall_pct = 40;
                endcase
            end
            stretch_left--;
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (idling_on && $urandom_range(0, 99) < stall_pct) begin
                m_ready <= 1'b0;
                stall_left = $urandom_range(0, 9);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_tick(logic [NUM_KEYS-1:0] levels);
        if (idling_on && $urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_key_levels <= levels;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_tick(levels);
        @(negedge aclk);
    endtask

    // stop sending and let every pending event come out
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        sb.set_reg(idx, data);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_config(int ft, int lt, int lvl);
        write_reg(CFG_FILTER_TIME, CFG_DATA_W'(ft));
        write_reg(CFG_LONG_TIME, CFG_DATA_W'(lt));
        write_reg(CFG_PRESSED_LEVEL, CFG_DATA_W'(lvl));
        n_settings++;
    endtask

    function automatic logic [NUM_KEYS-1:0] next_levels(int span);
        logic [NUM_KEYS-1:0] lv;
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (run_left[k] <= 0) begin
                target[k]   = ~target[k];
                run_left[k] = $urandom_range(1, span);
            end
            run_left[k]--;
        end
        lv = target;
        if ($urandom_range(0, 9) == 0) begin
            lv = NUM_KEYS'($urandom);
        end else begin
            // short glitches on single keys
            for (int k = 0; k < NUM_KEYS; k++)
                if ($urandom_range(0, 15) == 0) lv[k] = ~lv[k];
        end
        return lv;
    endfunction

    initial begin
        int ft;
        int lt;
        int lvl;
        int span;
        sb = new();
        aresetn      <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_index    <= '0;
        cfg_wdata    <= '0;
        s_valid      <= 1'b0;
        s_key_levels <= '0;
        gap_pct = 30;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: reset settings, then zero filter and zero long time
        send_tick(3'b000);
        send_tick(3'b111);
        wait_idle();
        write_reg(CFG_UNUSED, 16'hFFFF);
        set_config(0, 0, 0);
        send_tick(3'b000);
        send_tick(3'b000);
        send_tick(3'b000);
        send_tick(3'b111);
        send_tick(3'b101);
        send_tick(3'b010);
        send_tick(3'b111);
        wait_idle();

        // directed: filter lowered below a running count, pressed level high
        set_config(10, 16'hFFFF, 1);
        repeat (5) send_tick(3'b111);
        wait_idle();
        write_reg(CFG_FILTER_TIME, 16'd2);
        send_tick(3'b111);
        repeat (6) send_tick(3'b000);
        wait_idle();

        // 20-tick filter on all keys, long event shortly after the press
        gap_pct = 0;
        set_config(20, 2, 1);
        repeat (25) send_tick(3'b111);
        repeat (23) send_tick(3'b000);
        wait_idle();

        // random rounds, the last one with no idling at all
        for (int r = 0; r < NUM_ROUNDS; r++) begin
            wait_idle();
            case (r)
                0: begin ft = 0; lt = 0; end
                1: begin ft = $urandom_range(1, 3); lt = 16'hFFFF; end
                default: begin ft = $urandom_range(0, 4); lt = $urandom_range(0, 12); end
            endcase
            lvl = $urandom_range(0, 1);
            set_config(ft, lt, lvl);
            idling_on = (r != NUM_ROUNDS - 1);
            case ($urandom_range(0, 2))
                0: gap_pct = 0;
                1: gap_pct = 20;
                default: gap_pct = 45;
            endcase
            span = ft + ((lt > 20) ? 20 : lt) + 4;
            for (int k = 0; k < NUM_KEYS; k++)
                run_left[k] = $urandom_range(1, span);
            target = NUM_KEYS'($urandom);
            for (int i = 0; i < ROUND_TICKS; i++) begin
                if (r == 3 && i == ROUND_TICKS / 2) wait_idle();
                send_tick(next_levels(span));
            end
        end

        wait_idle();
        repeat (20) @(negedge aclk);
        if (sb.pending.size() != 0) sb.errors++;

        $display("run covered %0d scan ticks and %0d key events over %0d register settings",
                 sb.n_ticks, sb.n_events, n_settings);
        $display("including zero and lowered filter times, both pressed levels and output stalls");
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> files.f
sv/kdlp_pkg.sv
sv/kdlp_front.sv
sv/kdlp_queue.sv
sv/kdlp_back.sv
sv/key_debounce_long_press.sv
sv/kdlp_checker.sv
verif/tb_key_debounce_long_press.sv
